### design/kmc_pkg.sv
`default_nettype none
package kmc_pkg;

  localparam int MAX_VERTICES_DEF = 256;
  localparam int MAX_EDGES_DEF    = 1024;

  localparam logic [10:0] CUT_ALL_ONES = 11'h7FF;

  localparam logic [1:0] MODE_ADD   = 2'd0;
  localparam logic [1:0] MODE_DRAW  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_REJECT = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;

  localparam logic CFG_VERTEX_COUNT = 1'b0;
  localparam logic CFG_RUN_LIMIT    = 1'b1;

  typedef enum logic [1:0] {
    UF_INIT,
    UF_FIND,
    UF_LINK
  } uf_op_t;

  typedef struct packed {
    logic   start;
    uf_op_t op;
  } uf_req_t;

  typedef enum logic [2:0] {
    U_IDLE,
    U_INIT,
    U_RD,
    U_CHK,
    U_CRD,
    U_CWT
  } uf_state_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_INIT_GO,
    S_INIT_WT,
    S_COPY_RD,
    S_COPY_WR,
    S_DECIDE,
    S_DIV,
    S_EDGE_RD,
    S_EDGE_WT,
    S_FA_GO,
    S_FA_WT,
    S_FB_GO,
    S_FB_WT,
    S_SHIFT_CHK,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_END,
    S_CUT_CHK,
    S_CUT_RD,
    S_CUT_WT,
    S_FIN,
    S_OUT
  } ctl_state_t;

endpackage
`default_nettype wire

### design/kmc_uf.sv
`default_nettype none
module kmc_uf import kmc_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int VW           = $clog2(MAX_VERTICES)
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire uf_req_t       req,
  input  wire logic [VW-1:0] x,
  input  wire logic [VW-1:0] y,
  output logic               done,
  output logic [VW-1:0]      root
);

  logic [VW-1:0] parent_mem [MAX_VERTICES];
  logic [VW-1:0] rdata_r;

  uf_state_t     state_r, state_nxt;
  logic [VW-1:0] cur_r, cur_nxt;
  logic [VW-1:0] x_r, x_nxt;
  logic [VW-1:0] root_r, root_nxt;
  logic          done_r, done_nxt;
  logic          we;
  logic [VW-1:0] waddr, wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      parent_mem[waddr] <= wdata;
    end
    rdata_r <= parent_mem[cur_r];
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      U_IDLE: begin
        if (req.start) begin
          case (req.op)
            UF_INIT: state_nxt = U_INIT;
            UF_FIND: state_nxt = U_RD;
            default: state_nxt = U_IDLE;
          endcase
        end
      end
      U_INIT: if (cur_r == VW'(MAX_VERTICES - 1)) state_nxt = U_IDLE;
      U_RD:   state_nxt = U_CHK;
      U_CHK: begin
        if (rdata_r == cur_r) begin
          state_nxt = (x_r == cur_r) ? U_IDLE : U_CRD;
        end else begin
          state_nxt = U_RD;
        end
      end
      U_CRD:  state_nxt = U_CWT;
      U_CWT:  if (rdata_r == root_r) state_nxt = U_IDLE;
                else state_nxt = U_CRD;
      default: state_nxt = U_IDLE;
    endcase
  end

  always_comb begin
    cur_nxt  = cur_r;
    x_nxt    = x_r;
    root_nxt = root_r;
    done_nxt = 1'b0;
    we       = 1'b0;
    waddr    = cur_r;
    wdata    = root_r;
    case (state_r)
      U_IDLE: begin
        if (req.start) begin
          case (req.op)
            UF_INIT: cur_nxt = '0;
            UF_FIND: begin
              cur_nxt = x;
              x_nxt   = x;
            end
            UF_LINK: begin
              we       = 1'b1;
              waddr    = x;
              wdata    = y;
              done_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end
      U_INIT: begin
        we    = 1'b1;
        wdata = cur_r;
        if (cur_r == VW'(MAX_VERTICES - 1)) done_nxt = 1'b1;
        else cur_nxt = cur_r + 1'b1;
      end
      U_CHK: begin
        if (rdata_r == cur_r) begin
          root_nxt = cur_r;
          cur_nxt  = x_r;
          if (x_r == cur_r) done_nxt = 1'b1;
        end else begin
          cur_nxt = rdata_r;
        end
      end
      U_CWT: begin
        // path compression: point this node straight at the root
        we      = 1'b1;
        cur_nxt = rdata_r;
        if (rdata_r == root_r) done_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= U_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r  <= cur_nxt;
    x_r    <= x_nxt;
    root_r <= root_nxt;
  end

  assign done = done_r;
  assign root = root_r;

endmodule
`default_nettype wire

### design/karger_min_cut_contraction_unit.sv
// Karger min-cut contraction unit.
// Input channel (in_valid/in_stall) takes one transaction per item: mode 0 adds
// an edge, mode 1 runs one contraction step, mode 2 clears the graph, mode 3
// is a no-op. Every item gives exactly one result on the out_ channel.
// cfg_we/cfg_index/cfg_data write vertex_count (0) and run_count_limit (1).
// Add, clear and no-op go straight to the output stage; the next input is taken
// once that result has been loaded. A draw that opens a run first initializes
// the parent table and copies the loaded edges. A contraction step runs a
// bit-serial modulo, two root finds (walking each link and compressing each
// node on the path) and an order-keeping shift of every edge behind the
// picked one. A draw that ends the run then walks all loaded edges, two finds each.
// Reset empties the graph and the batch; the memories keep no reset value.
// While a result waits under out_stall the next item is still taken; its own
// result then waits in the unit until the output register frees.
`default_nettype none
module karger_min_cut_contraction_unit import kmc_pkg::*; #(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = MAX_EDGES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic [7:0]  in_first_vertex,
  input  wire logic [7:0]  in_second_vertex,
  input  wire logic [31:0] in_random_word,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic             out_run_done,
  output logic             out_batch_done,
  output logic [10:0]      out_cut_edges,
  output logic [10:0]      out_min_cut
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int IW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int EW = 2 * VW;

  logic [EW-1:0] orig_mem [MAX_EDGES];
  logic [EW-1:0] work_mem [MAX_EDGES];
  logic [EW-1:0] orig_rd_r, work_rd_r;
  logic          orig_we, work_we;
  logic [EW-1:0] orig_wdata, work_wdata;
  logic [IW-1:0] orig_waddr, work_waddr, work_raddr;

  ctl_state_t    state_r, state_nxt;
  logic [8:0]    vc_r;
  logic [15:0]   rl_r;
  logic [CW-1:0] loaded_r, loaded_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [8:0]    sn_r, sn_nxt;
  logic          active_r, active_nxt;
  logic [15:0]   runs_r, runs_nxt;
  logic [10:0]   best_r, best_nxt;
  logic [31:0]   word_r, word_nxt;
  logic [CW-1:0] rmd_r, rmd_nxt;
  logic [4:0]    bit_r, bit_nxt;
  logic [CW-1:0] i_r, i_nxt;
  logic [VW-1:0] a_r, a_nxt, b_r, b_nxt, r1_r, r1_nxt;
  logic          cut_phase_r, cut_phase_nxt;
  logic [10:0]   cnt_r, cnt_nxt;
  logic [1:0]    status_r, status_nxt;
  logic          rdone_r, rdone_nxt, bdone_r, bdone_nxt;
  logic [10:0]   cut_r, cut_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_load;

  logic [1:0]    out_status_r;
  logic          out_run_done_r, out_batch_done_r;
  logic [10:0]   out_cut_r, out_min_r;

  uf_req_t       uf_req;
  logic [VW-1:0] uf_x, uf_y, uf_root;
  logic          uf_done;

  logic          in_acc;
  logic [12:0]   eff_w;
  logic          add_ok;
  logic [CW-1:0] ip1;
  logic [CW:0]   div_try, div_s;
  logic [15:0]   runs_inc, limit;

  kmc_uf #(.MAX_VERTICES(MAX_VERTICES), .VW(VW)) u_uf (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (uf_req),
    .x     (uf_x),
    .y     (uf_y),
    .done  (uf_done),
    .root  (uf_root)
  );

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign eff_w    = (13'(vc_r) > 13'(MAX_VERTICES)) ? 13'(MAX_VERTICES) : 13'(vc_r);
  assign add_ok   = !active_r && (loaded_r != CW'(MAX_EDGES)) &&
                    (13'(in_first_vertex) < eff_w) && (13'(in_second_vertex) < eff_w);
  assign ip1      = i_r + 1'b1;
  assign div_try  = {rmd_r, word_r[31]};
  assign div_s    = (div_try >= {1'b0, rem_r}) ? (div_try - {1'b0, rem_r}) : div_try;
  assign runs_inc = runs_r + 16'd1;
  assign limit    = (rl_r == 16'd0) ? 16'd1 : rl_r;
  assign out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);

  // edge stores
  assign work_raddr = (state_r == S_SHIFT_RD) ? ip1[IW-1:0] : i_r[IW-1:0];

  always_ff @(posedge clk) begin
    if (orig_we) begin
      orig_mem[orig_waddr] <= orig_wdata;
    end
    orig_rd_r <= orig_mem[i_r[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (work_we) begin
      work_mem[work_waddr] <= work_wdata;
    end
    work_rd_r <= work_mem[work_raddr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_mode == MODE_DRAW && (active_r || loaded_r != '0)) begin
            state_nxt = active_r ? S_DECIDE : S_INIT_GO;
          end else begin
            state_nxt = S_OUT;
          end
        end
      end
      S_INIT_GO:  state_nxt = S_INIT_WT;
      S_INIT_WT:  if (uf_done) state_nxt = S_COPY_RD;
      S_COPY_RD:  state_nxt = S_COPY_WR;
      S_COPY_WR:  state_nxt = (ip1 == loaded_r) ? S_DECIDE : S_COPY_RD;
      S_DECIDE:   state_nxt = (sn_r > 9'd2 && rem_r != '0) ? S_DIV : S_CUT_CHK;
      S_DIV:      if (bit_r == 5'd31) state_nxt = S_EDGE_RD;
      S_EDGE_RD:  state_nxt = S_EDGE_WT;
      S_EDGE_WT:  state_nxt = S_FA_GO;
      S_FA_GO:    state_nxt = S_FA_WT;
      S_FA_WT:    if (uf_done) state_nxt = S_FB_GO;
      S_FB_GO:    state_nxt = S_FB_WT;
      S_FB_WT:    if (uf_done) state_nxt = cut_phase_r ? S_CUT_CHK : S_SHIFT_CHK;
      S_SHIFT_CHK: state_nxt = (ip1 < rem_r) ? S_SHIFT_RD : S_END;
      S_SHIFT_RD: state_nxt = S_SHIFT_WR;
      S_SHIFT_WR: state_nxt = S_SHIFT_CHK;
      S_END:      state_nxt = (sn_r <= 9'd2 || rem_r == '0) ? S_CUT_CHK : S_OUT;
      S_CUT_CHK:  state_nxt = (i_r == loaded_r) ? S_FIN : S_CUT_RD;
      S_CUT_RD:   state_nxt = S_CUT_WT;
      S_CUT_WT:   state_nxt = S_FA_GO;
      S_FIN:      state_nxt = S_OUT;
      S_OUT:      if (out_load) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    loaded_nxt    = loaded_r;
    rem_nxt       = rem_r;
    sn_nxt        = sn_r;
    active_nxt    = active_r;
    runs_nxt      = runs_r;
    best_nxt      = best_r;
    word_nxt      = word_r;
    rmd_nxt       = rmd_r;
    bit_nxt       = bit_r;
    i_nxt         = i_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    r1_nxt        = r1_r;
    cut_phase_nxt = cut_phase_r;
    cnt_nxt       = cnt_r;
    status_nxt    = status_r;
    rdone_nxt     = rdone_r;
    bdone_nxt     = bdone_r;
    cut_nxt       = cut_r;
    orig_we       = 1'b0;
    orig_waddr    = loaded_r[IW-1:0];
    orig_wdata    = {VW'(in_first_vertex), VW'(in_second_vertex)};
    work_we       = 1'b0;
    work_waddr    = i_r[IW-1:0];
    work_wdata    = orig_rd_r;
    uf_req.start  = 1'b0;
    uf_req.op     = UF_FIND;
    uf_x          = a_r;
    uf_y          = uf_root;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          word_nxt   = in_random_word;
          status_nxt = ST_OK;
          rdone_nxt  = 1'b0;
          bdone_nxt  = 1'b0;
          cut_nxt    = '0;
          case (in_mode)
            MODE_ADD: begin
              if (add_ok) begin
                orig_we    = 1'b1;
                loaded_nxt = loaded_r + 1'b1;
              end else begin
                status_nxt = ST_REJECT;
              end
            end
            MODE_CLEAR: begin
              loaded_nxt = '0;
              rem_nxt    = '0;
              sn_nxt     = '0;
              active_nxt = 1'b0;
              runs_nxt   = '0;
              best_nxt   = CUT_ALL_ONES;
            end
            MODE_DRAW: begin
              if (!active_r && loaded_r == '0) status_nxt = ST_EMPTY;
            end
            default: ;
          endcase
        end
      end
      S_INIT_GO: begin
        uf_req.start = 1'b1;
        uf_req.op    = UF_INIT;
        i_nxt        = '0;
      end
      S_COPY_WR: begin
        work_we = 1'b1;
        if (ip1 == loaded_r) begin
          rem_nxt    = loaded_r;
          sn_nxt     = eff_w[8:0];
          active_nxt = 1'b1;
        end else begin
          i_nxt = ip1;
        end
      end
      S_DECIDE: begin
        rmd_nxt       = '0;
        bit_nxt       = '0;
        i_nxt         = '0;
        cnt_nxt       = '0;
        cut_phase_nxt = !(sn_r > 9'd2 && rem_r != '0);
      end
      S_DIV: begin
        // one quotient bit per cycle; only the remainder is kept
        rmd_nxt  = div_s[CW-1:0];
        word_nxt = {word_r[30:0], 1'b0};
        bit_nxt  = bit_r + 1'b1;
        if (bit_r == 5'd31) i_nxt = div_s[CW-1:0];
      end
      S_EDGE_WT: begin
        a_nxt = work_rd_r[EW-1:VW];
        b_nxt = work_rd_r[VW-1:0];
      end
      S_CUT_WT: begin
        a_nxt = orig_rd_r[EW-1:VW];
        b_nxt = orig_rd_r[VW-1:0];
      end
      S_FA_GO: begin
        uf_req.start = 1'b1;
        uf_x         = a_r;
      end
      S_FA_WT: if (uf_done) r1_nxt = uf_root;
      S_FB_GO: begin
        uf_req.start = 1'b1;
        uf_x         = b_r;
      end
      S_FB_WT: begin
        if (uf_done) begin
          if (cut_phase_r) begin
            if (r1_r != uf_root && cnt_r != CUT_ALL_ONES) cnt_nxt = cnt_r + 1'b1;
            i_nxt = ip1;
          end else if (r1_r != uf_root) begin
            // first root goes under the second
            uf_req.start = 1'b1;
            uf_req.op    = UF_LINK;
            uf_x         = r1_r;
            uf_y         = uf_root;
            sn_nxt       = sn_r - 1'b1;
          end
        end
      end
      S_SHIFT_CHK: if (!(ip1 < rem_r)) rem_nxt = rem_r - 1'b1;
      S_SHIFT_WR: begin
        work_we    = 1'b1;
        work_wdata = work_rd_r;
        i_nxt      = ip1;
      end
      S_END: begin
        i_nxt         = '0;
        cnt_nxt       = '0;
        cut_phase_nxt = 1'b1;
      end
      S_FIN: begin
        active_nxt = 1'b0;
        rdone_nxt  = 1'b1;
        cut_nxt    = cnt_r;
        if (cnt_r < best_r) best_nxt = cnt_r;
        runs_nxt   = runs_inc;
        bdone_nxt  = (runs_inc >= limit);
      end
      S_OUT: begin
        if (out_load && bdone_r) begin
          runs_nxt = '0;
          best_nxt = CUT_ALL_ONES;
        end
      end
      default: ;
    endcase
    out_valid_nxt = out_load ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      vc_r        <= '0;
      rl_r        <= 16'd1;
      loaded_r    <= '0;
      rem_r       <= '0;
      sn_r        <= '0;
      active_r    <= 1'b0;
      runs_r      <= '0;
      best_r      <= CUT_ALL_ONES;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      rem_r       <= rem_nxt;
      sn_r        <= sn_nxt;
      active_r    <= active_nxt;
      runs_r      <= runs_nxt;
      best_r      <= best_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_VERTEX_COUNT: vc_r <= cfg_data[8:0];
          CFG_RUN_LIMIT:    rl_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    word_r      <= word_nxt;
    rmd_r       <= rmd_nxt;
    bit_r       <= bit_nxt;
    i_r         <= i_nxt;
    a_r         <= a_nxt;
    b_r         <= b_nxt;
    r1_r        <= r1_nxt;
    cut_phase_r <= cut_phase_nxt;
    cnt_r       <= cnt_nxt;
    status_r    <= status_nxt;
    rdone_r     <= rdone_nxt;
    bdone_r     <= bdone_nxt;
    cut_r       <= cut_nxt;
    if (out_load) begin
      out_status_r     <= status_r;
      out_run_done_r   <= rdone_r;
      out_batch_done_r <= bdone_r;
      out_cut_r        <= cut_r;
      out_min_r        <= best_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_run_done   = out_run_done_r;
  assign out_batch_done = out_batch_done_r;
  assign out_cut_edges  = out_cut_r;
  assign out_min_cut    = out_min_r;

`ifndef ASSERT_OFF
  a_batch_needs_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_batch_done |-> out_run_done)
    else $error("batch end without run end");

  a_err_no_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> !out_run_done && !out_batch_done)
    else $error("rejected item finished a run");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rem_r <= loaded_r)
    else $error("remaining edges exceed loaded edges");

  a_min_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_run_done && !$past(out_valid && out_stall) |-> out_min_cut <= out_cut_edges)
    else $error("min cut above finished cut");
`endif

endmodule
`default_nettype wire

### bench/tb_karger_min_cut_contraction_unit.sv
`default_nettype none
module tb_karger_min_cut_contraction_unit;
  import kmc_pkg::*;

  localparam int NV = MAX_VERTICES_DEF;
  localparam int NE = MAX_EDGES_DEF;
  localparam logic [1:0] MODE_NOP = 2'd3;
  localparam longint CYCLE_LIMIT = 64'd60_000_000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  in_mode;
  logic [7:0]  in_first_vertex;
  logic [7:0]  in_second_vertex;
  logic [31:0] in_random_word;
  logic        out_valid;
  logic        out_stall;
  logic [1:0]  out_status;
  logic        out_run_done;
  logic        out_batch_done;
  logic [10:0] out_cut_edges;
  logic [10:0] out_min_cut;

  karger_min_cut_contraction_unit i_dut (.*);

  typedef struct packed {
    logic [1:0]  status;
    logic        run_done;
    logic        batch_done;
    logic [10:0] cut_edges;
    logic [10:0] min_cut;
  } cut_result_t;

  // shadow state of the contraction engine
  logic [7:0]  edge_a_orig [NE];
  logic [7:0]  edge_b_orig [NE];
  logic [7:0]  edge_a_work [NE];
  logic [7:0]  edge_b_work [NE];
  logic [7:0]  uf_parent [NV];
  int unsigned n_loaded, n_remaining, n_super, runs_done;
  bit          in_run;
  logic [10:0] best_so_far;
  logic [8:0]  vcount_reg;
  logic [15:0] run_limit_reg;

  cut_result_t expected_results[$];
  bit          failed;
  longint      cycle_count;
  bit          out_hold;
  int          out_idle_pct;
  int          in_idle_pct;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic int unsigned eff_vcount();
    return (vcount_reg > NV) ? NV : vcount_reg;
  endfunction

  function automatic int unsigned find_root(int unsigned x);
    int unsigned r, nxt, steps;
    r = x % NV;
    steps = 0;
    while (uf_parent[r] != r && steps < NV) begin
      r = uf_parent[r];
      steps++;
    end
    x = x % NV;
    steps = 0;
    while (x != r && steps < NV) begin
      nxt = uf_parent[x];
      uf_parent[x] = r[7:0];
      x = nxt;
      steps++;
    end
    return r;
  endfunction

  function automatic cut_result_t predict_item(logic [1:0] mode, logic [7:0] va,
                                               logic [7:0] vb, logic [31:0] word);
    cut_result_t res;
    int unsigned idx, r1, r2, c, lim;
    res = '0;
    case (mode)
      MODE_ADD: begin
        if (in_run || n_loaded >= NE || va >= eff_vcount() || vb >= eff_vcount()) begin
          res.status = ST_REJECT;
        end else begin
          edge_a_orig[n_loaded] = va;
          edge_b_orig[n_loaded] = vb;
          n_loaded++;
        end
      end
      MODE_CLEAR: begin
        n_loaded = 0;
        n_remaining = 0;
        n_super = 0;
        in_run = 0;
        runs_done = 0;
        best_so_far = CUT_ALL_ONES;
      end
      MODE_DRAW: begin
        if (!in_run && n_loaded == 0) begin
          res.status = ST_EMPTY;
        end else begin
          if (!in_run) begin
            for (int i = 0; i < NV; i++) uf_parent[i] = i[7:0];
            edge_a_work = edge_a_orig;
            edge_b_work = edge_b_orig;
            n_remaining = n_loaded;
            n_super = eff_vcount();
            in_run = 1;
          end
          if (n_super > 2 && n_remaining > 0) begin
            idx = word % n_remaining;
            r1 = find_root(edge_a_work[idx]);
            r2 = find_root(edge_b_work[idx]);
            if (r1 != r2) begin
              n_super--;
              uf_parent[r1] = r2[7:0];
            end
            for (int unsigned i = idx; i + 1 < n_remaining; i++) begin
              edge_a_work[i] = edge_a_work[i+1];
              edge_b_work[i] = edge_b_work[i+1];
            end
            n_remaining--;
          end
          if (n_super <= 2 || n_remaining == 0) begin
            lim = (run_limit_reg == 0) ? 1 : run_limit_reg;
            c = 0;
            for (int unsigned i = 0; i < n_loaded; i++)
              if (find_root(edge_a_orig[i]) != find_root(edge_b_orig[i])) c++;
            if (c > CUT_ALL_ONES) c = CUT_ALL_ONES;
            res.cut_edges = c[10:0];
            res.run_done = 1;
            in_run = 0;
            if (c < best_so_far) best_so_far = c[10:0];
            runs_done = (runs_done + 1) & 16'hFFFF;
            if (runs_done >= lim) res.batch_done = 1;
          end
        end
      end
      default: ;
    endcase
    res.min_cut = best_so_far;
    if (res.batch_done) begin
      runs_done = 0;
      best_so_far = CUT_ALL_ONES;
    end
    return res;
  endfunction

  // result checker and receiver stall
  always @(posedge clk) begin
    cut_result_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction");
        failed = 1;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_status !== exp_res.status) begin
          $error("status exp %0d got %0d", exp_res.status, out_status); failed = 1;
        end
        if (out_run_done !== exp_res.run_done) begin
          $error("run_done exp %0d got %0d", exp_res.run_done, out_run_done); failed = 1;
        end
        if (out_batch_done !== exp_res.batch_done) begin
          $error("batch_done exp %0d got %0d", exp_res.batch_done, out_batch_done);
          failed = 1;
        end
        if (out_cut_edges !== exp_res.cut_edges) begin
          $error("cut_edges exp %0d got %0d", exp_res.cut_edges, out_cut_edges); failed = 1;
        end
        if (out_min_cut !== exp_res.min_cut) begin
          $error("min_cut exp %0d got %0d", exp_res.min_cut, out_min_cut); failed = 1;
        end
      end
    end
    out_stall <= out_hold || ($urandom_range(99) < out_idle_pct);
  end

  // in_valid stays high after a transaction; drain() drops it when sending stops
  task automatic send_item(logic [1:0] mode, logic [7:0] va, logic [7:0] vb,
                           logic [31:0] word);
    cut_result_t exp_res;
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid <= 1;
    in_mode <= mode;
    in_first_vertex <= va;
    in_second_vertex <= vb;
    in_random_word <= word;
    do @(posedge clk); while (in_stall);
    exp_res = predict_item(mode, va, vb, word);
    expected_results = {expected_results, exp_res};
  endtask

  task automatic drain();
    in_valid <= 0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] val);
    drain();
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CFG_VERTEX_COUNT) vcount_reg = val[8:0];
    else run_limit_reg = val;
  endtask

  task automatic add_edge(int unsigned nv);
    send_item(MODE_ADD, 8'($urandom_range(nv - 1)), 8'($urandom_range(nv - 1)), $urandom);
  endtask

  // draw until the current run finishes
  task automatic finish_run();
    int guard;
    guard = 0;
    do begin
      send_item(MODE_DRAW, 8'($urandom), 8'($urandom), $urandom);
      guard++;
    end while (in_run && guard < 600);
  endtask

  task automatic test_directed();
    write_cfg(CFG_VERTEX_COUNT, 16'd0);
    send_item(MODE_ADD, 8'd0, 8'd0, 32'd0);          // rejected, no vertices
    send_item(MODE_DRAW, 8'd0, 8'd0, 32'hFFFF_FFFF); // empty graph
    send_item(MODE_NOP, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
    write_cfg(CFG_VERTEX_COUNT, 16'd511);             // saturates at max
    write_cfg(CFG_RUN_LIMIT, 16'd0);                  // acts as one
    send_item(MODE_ADD, 8'd255, 8'd0, 32'd0);
    send_item(MODE_ADD, 8'd0, 8'd255, 32'd0);
    send_item(MODE_ADD, 8'd7, 8'd7, 32'd0);           // self loop
    send_item(MODE_ADD, 8'hAA, 8'h55, 32'd0);
    send_item(MODE_DRAW, 8'd0, 8'd0, 32'hFFFF_FFFF);
    send_item(MODE_ADD, 8'd1, 8'd2, 32'd0);           // rejected, run active
    send_item(MODE_CLEAR, 8'd0, 8'd0, 32'd0);         // aborts run
    write_cfg(CFG_VERTEX_COUNT, 16'd2);               // small graph
    send_item(MODE_ADD, 8'd0, 8'd1, 32'd0);
    send_item(MODE_ADD, 8'd2, 8'd1, 32'd0);           // out of range
    send_item(MODE_DRAW, 8'd0, 8'd0, 32'h8000_0000);
    write_cfg(CFG_VERTEX_COUNT, 16'd256);
    write_cfg(CFG_RUN_LIMIT, 16'd2);
    send_item(MODE_DRAW, 8'd0, 8'd0, 32'h1);          // stale edge, new vcount
    finish_run();
    send_item(MODE_CLEAR, 8'hFF, 8'hFF, 32'hFFFF_FFFF);
  endtask

  // well-formed batches on small graphs with some noise mixed in
  task automatic test_random_batches(int items);
    int unsigned nv, ne, sent;
    sent = 0;
    while (sent < items) begin
      nv = $urandom_range(3, 12);
      ne = $urandom_range(1, 20);
      send_item(MODE_CLEAR, 8'($urandom), 8'($urandom), $urandom);
      write_cfg(CFG_VERTEX_COUNT, 16'(nv));
      write_cfg(CFG_RUN_LIMIT, 16'($urandom_range(1, 4)));
      for (int i = 0; i < ne; i++) begin
        if ($urandom_range(9) == 0)
          send_item(MODE_ADD, 8'($urandom), 8'($urandom), $urandom);
        else
          add_edge(nv);
        sent++;
      end
      repeat ($urandom_range(1, 4)) begin
        finish_run();
        sent += 4;
        if ($urandom_range(7) == 0) begin
          send_item(2'($urandom), 8'($urandom), 8'($urandom), $urandom);
          sent++;
        end
      end
    end
  endtask

  task automatic test_backpressure();
    send_item(MODE_CLEAR, 8'd0, 8'd0, 32'd0);
    write_cfg(CFG_VERTEX_COUNT, 16'd8);
    out_hold = 1;
    fork
      begin
        repeat (400) @(posedge clk);
        out_hold = 0;
      end
      for (int i = 0; i < 12; i++) add_edge(8);
    join
    drain();
    finish_run();
  endtask

  task automatic test_large_graph();
    send_item(MODE_CLEAR, 8'd0, 8'd0, 32'd0);
    write_cfg(CFG_VERTEX_COUNT, 16'd256);
    write_cfg(CFG_RUN_LIMIT, 16'hFFFF);
    in_idle_pct = 0;
    out_idle_pct = 0;
    for (int i = 0; i < 120; i++) add_edge(256);
    send_item(MODE_DRAW, 8'd0, 8'd0, 32'hFFFF_FFFF);
    send_item(MODE_DRAW, 8'd0, 8'd0, $urandom);
    in_idle_pct = 13;
    out_idle_pct = 13;
  endtask

  initial begin
    failed = 0;
    cycle_count = 0;
    out_hold = 0;
    in_idle_pct = 13;
    out_idle_pct = 13;
    rst_n = 0;
    cfg_we = 0;
    cfg_index = CFG_VERTEX_COUNT;
    cfg_data = '0;
    in_valid = 0;
    in_mode = MODE_NOP;
    in_first_vertex = '0;
    in_second_vertex = '0;
    in_random_word = '0;
    out_stall = 0;
    n_loaded = 0; n_remaining = 0; n_super = 0; runs_done = 0; in_run = 0;
    best_so_far = CUT_ALL_ONES;
    vcount_reg = '0;
    run_limit_reg = 16'd1;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random_batches(150);
    in_idle_pct = 0;
    out_idle_pct = 0;
    test_random_batches(80);                        // no idling stretch
    in_idle_pct = 13;
    out_idle_pct = 13;
    test_random_batches(150);
    test_large_graph();
    drain();
    if (!failed) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

### karger_min_cut_contraction_unit.f
design/kmc_pkg.sv
design/kmc_uf.sv
design/karger_min_cut_contraction_unit.sv
bench/tb_karger_min_cut_contraction_unit.sv
